/* hdl/seam_carving_retarget_macros.svh */
// Assertion macros used by the seam carving checker file.
`ifndef SEAM_CARVING_RETARGET_MACROS_SVH
`define SEAM_CARVING_RETARGET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/scr_pkg.sv */
// Shared constants, payload types and control structs for the seam carving block.
`timescale 1ns / 1ps

package scr_pkg;

  // Image size limits and derived widths.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int POS_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CNT_W      = POS_W + 1;
  localparam int MAX_LEN    = 1 << POS_W;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int TOT_W      = ADDR_W + 1;

  // Pixel, energy and cost widths.
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int ENERGY_W = 11;
  localparam int COST_W   = ENERGY_W + POS_W;

  // Configuration port.
  localparam int DIM_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARVE_ROWS    = 2'd3;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              last_pixel;
    logic              past_end;
  } pixel_out_t;

  // Pixel store read address sources.
  typedef enum logic [2:0] {
    PS_READ,
    PS_HERE,
    PS_LEFT,
    PS_UP,
    PS_NEXT
  } pix_sel_t;

  // Previous cost line read address sources.
  typedef enum logic [1:0] {
    PV_LEFT,
    PV_CENTER,
    PV_RIGHT
  } prev_sel_t;

  typedef struct packed {
    logic      load_pix;
    logic      out_capture;
    logic      set_carved;
    pix_sel_t  pix_sel;
    logic      here_latch;
    logic      nb_latch;
    logic      en_write;
    logic      en_next;
    prev_sel_t prev_sel;
    logic      dp_latch_left;
    logic      dp_latch_center;
    logic      dp_write;
    logic      p_clear;
    logic      p_inc;
    logic      p_from_pos;
    logic      s_clear;
    logic      s_inc;
    logic      s_dec;
    logic      bank_toggle;
    logic      cur_init;
    logic      cur_dec;
    logic      bt_start;
    logic      rc_start;
    logic      pos_bp;
    logic      i_inc;
    logic      shift_write;
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic load_last;
    logic p_more_len;
    logic p_more_cur;
    logic s_more;
    logic s_zero;
    logic seam_due;
    logic shift_more;
    logic rc_do;
  } status_t;

endpackage

/* hdl/scr_datapath.sv */
// Datapath: image stores, cost lines, loop counters and energy arithmetic.
`timescale 1ns / 1ps

module scr_datapath import scr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pixel_in_t             in_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output pixel_out_t            out_data
);

  // Configuration registers.
  logic [DIM_W-1:0] width_raw;
  logic [DIM_W-1:0] height_raw;
  logic [DIM_W-1:0] target_raw;
  logic             carve_rows;

  // Image bookkeeping.
  logic [TOT_W-1:0] load_count;
  logic [POS_W-1:0] load_x;
  logic [POS_W-1:0] load_y;
  logic [TOT_W-1:0] read_count;
  logic [POS_W-1:0] read_x;
  logic [POS_W-1:0] read_y;
  logic             carved;

  // Carving loop registers.
  logic [POS_W-1:0]  p;
  logic [POS_W-1:0]  s;
  logic [CNT_W-1:0]  cur;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  i;
  logic [POS_W-1:0]  best_end;
  logic [COST_W-1:0] best_cost;
  logic              bank;

  // Operand holding registers.
  logic [PIX_W-1:0]    here_pix;
  logic [PIX_W-1:0]    nb_pix;
  logic [COST_W-1:0]   l_cost;
  logic [COST_W-1:0]   c_cost;
  logic [ENERGY_W-1:0] e_hold;

  // Memories.
  logic [PIX_W-1:0]    pixel_mem  [DEPTH];
  logic [ENERGY_W-1:0] energy_mem [DEPTH];
  logic [POS_W-1:0]    bp_mem     [DEPTH];
  logic [COST_W-1:0]   cost_a     [MAX_LEN];
  logic [COST_W-1:0]   cost_b     [MAX_LEN];

  logic [PIX_W-1:0]    pix_rdata;
  logic [ENERGY_W-1:0] en_rdata;
  logic [POS_W-1:0]    bp_rdata;
  logic [COST_W-1:0]   cost_a_rd;
  logic [COST_W-1:0]   cost_b_rd;

  // Derived sizes.
  logic [CNT_W-1:0] eff_w;
  logic [CNT_W-1:0] eff_h;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] span;
  logic [DIM_W-1:0] tgt;
  logic [CNT_W-1:0] tgt_c;
  logic [CNT_W-1:0] out_w;
  logic [CNT_W-1:0] out_h;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] out_total;
  logic             read_ok;

  // Addresses and computed values.
  logic [POS_W-1:0]    q;
  logic [POS_W-1:0]    t;
  logic [POS_W-1:0]    i_plus;
  logic [ADDR_W-1:0]   pix_raddr;
  logic [ADDR_W-1:0]   pix_waddr;
  logic [PIX_W-1:0]    pix_wdata;
  logic                pix_we;
  logic [ADDR_W-1:0]   en_raddr;
  logic [ADDR_W-1:0]   en_waddr;
  logic [ENERGY_W-1:0] en_wdata;
  logic                en_we;
  logic [ADDR_W-1:0]   here_addr;
  logic [ADDR_W-1:0]   bp_raddr;
  logic [POS_W-1:0]    prev_addr;
  logic [COST_W-1:0]   prev_val;
  logic [ENERGY_W-1:0] energy_calc;
  logic [POS_W-1:0]    dp_b;
  logic [COST_W-1:0]   dp_bv;
  logic [COST_W-1:0]   dp_cost;
  logic                last_line;

  // Address of position p along the carve axis and s along the scan axis.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] pp,
                                                  input logic [POS_W-1:0] ss,
                                                  input logic rows);
    logic [ADDR_W-1:0] a;
    if (rows) begin
      a = {pp[ROW_W-1:0], ss[COL_W-1:0]};
    end else begin
      a = {ss[ROW_W-1:0], pp[COL_W-1:0]};
    end
    return a;
  endfunction

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Sum of channel differences between two packed pixels.
  function automatic logic [ENERGY_W-1:0] pix_diff(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
    logic [ENERGY_W-1:0] sum;
    sum = ENERGY_W'(abs_diff(a[3*CHAN_W-1:2*CHAN_W], b[3*CHAN_W-1:2*CHAN_W]))
        + ENERGY_W'(abs_diff(a[2*CHAN_W-1:CHAN_W], b[2*CHAN_W-1:CHAN_W]))
        + ENERGY_W'(abs_diff(a[CHAN_W-1:0], b[CHAN_W-1:0]));
    return sum;
  endfunction

  // Effective sizes with the registers saturated to their legal ranges.
  always_comb begin
    if (width_raw < DIM_W'(2)) begin
      eff_w = CNT_W'(2);
    end else if (32'(width_raw) > MAX_WIDTH) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(width_raw);
    end
    if (height_raw < DIM_W'(2)) begin
      eff_h = CNT_W'(2);
    end else if (32'(height_raw) > MAX_HEIGHT) begin
      eff_h = CNT_W'(MAX_HEIGHT);
    end else begin
      eff_h = CNT_W'(height_raw);
    end
  end

  assign len       = carve_rows ? eff_h : eff_w;
  assign span      = carve_rows ? eff_w : eff_h;
  assign tgt       = (target_raw == '0) ? DIM_W'(1) : target_raw;
  assign tgt_c     = (32'(tgt) > 32'(len)) ? len : CNT_W'(tgt);
  assign out_w     = carve_rows ? eff_w : tgt_c;
  assign out_h     = carve_rows ? tgt_c : eff_h;
  assign total     = TOT_W'(eff_w) * TOT_W'(eff_h);
  assign out_total = TOT_W'(out_w) * TOT_W'(out_h);
  assign read_ok   = carved && (read_count < out_total);

  // Neighbor positions, mirrored at the first line.
  assign q         = (p == '0) ? POS_W'(1) : p - 1'b1;
  assign t         = (s == '0) ? POS_W'(1) : s - 1'b1;
  assign i_plus    = i + 1'b1;
  assign here_addr = cell_addr(p, s, carve_rows);
  assign bp_raddr  = cell_addr(pos, s, carve_rows);
  assign last_line = ({1'b0, s} + 1'b1) == span;

  // Status toward the controller.
  assign status.load_ok    = !carved && (load_count < total);
  assign status.load_last  = TOT_W'(load_count + 1'b1) == total;
  assign status.p_more_len = ({1'b0, p} + 1'b1) < len;
  assign status.p_more_cur = ({1'b0, p} + 1'b1) < cur;
  assign status.s_more     = ({1'b0, s} + 1'b1) < span;
  assign status.s_zero     = (s == '0);
  assign status.seam_due   = 32'(cur) > 32'(tgt);
  assign status.shift_more = ({1'b0, i} + 1'b1) < cur;
  assign status.rc_do      = ({1'b0, pos} + 1'b1) < cur;

  // Pixel store port selection.
  always_comb begin
    case (cmd.pix_sel)
      PS_READ: pix_raddr = {read_y[ROW_W-1:0], read_x[COL_W-1:0]};
      PS_HERE: pix_raddr = here_addr;
      PS_LEFT: pix_raddr = cell_addr(q, s, carve_rows);
      PS_UP:   pix_raddr = cell_addr(p, t, carve_rows);
      PS_NEXT: pix_raddr = cell_addr(i_plus, s, carve_rows);
      default: pix_raddr = here_addr;
    endcase
  end

  assign pix_we    = cmd.load_pix || cmd.shift_write;
  assign pix_waddr = cmd.load_pix ? {load_y[ROW_W-1:0], load_x[COL_W-1:0]}
                                  : cell_addr(i, s, carve_rows);
  assign pix_wdata = cmd.load_pix ? {in_data.red_in, in_data.green_in, in_data.blue_in}
                                  : pix_rdata;

  // Energy of the current pixel from its two neighbors.
  assign energy_calc = pix_diff(here_pix, nb_pix) + pix_diff(here_pix, pix_rdata);

  // Energy store port selection.
  assign en_raddr = cmd.en_next ? cell_addr(i_plus, s, carve_rows) : here_addr;
  assign en_we    = cmd.en_write || cmd.shift_write;
  assign en_waddr = cmd.en_write ? here_addr : cell_addr(i, s, carve_rows);
  assign en_wdata = cmd.en_write ? energy_calc : en_rdata;

  // Previous cost line read address, clamped at both ends of the line.
  always_comb begin
    case (cmd.prev_sel)
      PV_LEFT:   prev_addr = (p == '0) ? p : p - 1'b1;
      PV_CENTER: prev_addr = p;
      PV_RIGHT:  prev_addr = status.p_more_cur ? p + 1'b1 : p;
      default:   prev_addr = p;
    endcase
  end

  // The first line of every seam starts from zero cost.
  assign prev_val = status.s_zero ? '0 : (bank ? cost_a_rd : cost_b_rd);

  // Predecessor choice: center first, then left, then right.
  always_comb begin
    dp_b  = p;
    dp_bv = c_cost;
    if (l_cost < c_cost) begin
      dp_b  = p - 1'b1;
      dp_bv = l_cost;
    end
    if (prev_val < dp_bv) begin
      dp_b  = p + 1'b1;
      dp_bv = prev_val;
    end
    dp_cost = COST_W'(e_hold) + dp_bv;
  end

  // Image stores.
  always_ff @(posedge clk) begin
    if (pix_we) begin
      pixel_mem[pix_waddr] <= pix_wdata;
    end
    pix_rdata <= pixel_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      energy_mem[en_waddr] <= en_wdata;
    end
    en_rdata <= energy_mem[en_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.dp_write) begin
      bp_mem[here_addr] <= dp_b;
    end
    bp_rdata <= bp_mem[bp_raddr];
  end

  // Ping-pong cost lines; the line being written is selected by bank.
  always_ff @(posedge clk) begin
    if (cmd.dp_write && !bank) begin
      cost_a[p] <= dp_cost;
    end
    cost_a_rd <= cost_a[prev_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.dp_write && bank) begin
      cost_b[p] <= dp_cost;
    end
    cost_b_rd <= cost_b[prev_addr];
  end

  // Operand latches.
  always_ff @(posedge clk) begin
    if (cmd.here_latch) begin
      here_pix <= pix_rdata;
    end
    if (cmd.nb_latch) begin
      nb_pix <= pix_rdata;
    end
    if (cmd.dp_latch_left) begin
      l_cost <= prev_val;
      e_hold <= en_rdata;
    end
    if (cmd.dp_latch_center) begin
      c_cost <= prev_val;
    end
    if (cmd.dp_write && last_line && (p == '0 || dp_cost < best_cost)) begin
      best_cost <= dp_cost;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (cmd.out_capture) begin
      if (read_ok) begin
        out_data.red_out    <= pix_rdata[3*CHAN_W-1:2*CHAN_W];
        out_data.green_out  <= pix_rdata[2*CHAN_W-1:CHAN_W];
        out_data.blue_out   <= pix_rdata[CHAN_W-1:0];
        out_data.last_pixel <= TOT_W'(read_count + 1'b1) == out_total;
        out_data.past_end   <= 1'b0;
      end else begin
        out_data.red_out    <= '0;
        out_data.green_out  <= '0;
        out_data.blue_out   <= '0;
        out_data.last_pixel <= 1'b0;
        out_data.past_end   <= 1'b1;
      end
    end
  end

  // Configuration and image bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= DIM_W'(256);
      height_raw <= DIM_W'(256);
      target_raw <= DIM_W'(256);
      carve_rows <= 1'b0;
      load_count <= '0;
      load_x     <= '0;
      load_y     <= '0;
      read_count <= '0;
      read_x     <= '0;
      read_y     <= '0;
      carved     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_raw  <= cfg_data;
        REG_IMAGE_HEIGHT:  height_raw <= cfg_data;
        REG_TARGET_LENGTH: target_raw <= cfg_data;
        REG_CARVE_ROWS:    carve_rows <= cfg_data[0];
        default:           carve_rows <= carve_rows;
      endcase
      load_count <= '0;
      load_x     <= '0;
      load_y     <= '0;
      read_count <= '0;
      read_x     <= '0;
      read_y     <= '0;
      carved     <= 1'b0;
    end else begin
      if (cmd.load_pix) begin
        load_count <= load_count + 1'b1;
        if (({1'b0, load_x} + 1'b1) == eff_w) begin
          load_x <= '0;
          load_y <= load_y + 1'b1;
        end else begin
          load_x <= load_x + 1'b1;
        end
      end
      if (cmd.out_capture && read_ok) begin
        read_count <= read_count + 1'b1;
        if (({1'b0, read_x} + 1'b1) == out_w) begin
          read_x <= '0;
          read_y <= read_y + 1'b1;
        end else begin
          read_x <= read_x + 1'b1;
        end
      end
      if (cmd.set_carved) begin
        carved <= 1'b1;
      end
    end
  end

  // Carving loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      p        <= '0;
      s        <= '0;
      cur      <= '0;
      pos      <= '0;
      i        <= '0;
      best_end <= '0;
      bank     <= 1'b0;
    end else begin
      if (cmd.p_clear) begin
        p <= '0;
      end else if (cmd.p_inc) begin
        p <= p + 1'b1;
      end else if (cmd.p_from_pos) begin
        p <= pos;
      end
      if (cmd.s_clear) begin
        s <= '0;
      end else if (cmd.s_inc) begin
        s <= s + 1'b1;
      end else if (cmd.s_dec) begin
        s <= s - 1'b1;
      end else if (cmd.bt_start || cmd.rc_start) begin
        s <= POS_W'(span - 1'b1);
      end
      if (cmd.cur_init) begin
        cur <= len;
      end else if (cmd.cur_dec) begin
        cur <= cur - 1'b1;
      end
      if (cmd.bt_start || cmd.rc_start) begin
        pos <= best_end;
      end else if (cmd.pos_bp) begin
        pos <= bp_rdata;
      end
      if (cmd.bt_start) begin
        i <= best_end;
      end else if (cmd.pos_bp) begin
        i <= bp_rdata;
      end else if (cmd.i_inc) begin
        i <= i + 1'b1;
      end
      if (cmd.dp_write && last_line && (p == '0 || dp_cost < best_cost)) begin
        best_end <= p;
      end
      if (cmd.bank_toggle) begin
        bank <= !bank;
      end
    end
  end

endmodule

/* hdl/scr_ctrl.sv */
// Controller: sequences loading, reading, energy passes, seam search and removal.
`timescale 1ns / 1ps

module scr_ctrl import scr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    opcode,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready,
  output logic    out_valid
);

  typedef enum logic [20:0] {
    ST_IDLE       = 21'h000001,
    ST_READ_OUT   = 21'h000002,
    ST_EN_A       = 21'h000004,
    ST_EN_B       = 21'h000008,
    ST_EN_C       = 21'h000010,
    ST_EN_D       = 21'h000020,
    ST_SEAM_CHK   = 21'h000040,
    ST_DP_A       = 21'h000080,
    ST_DP_B       = 21'h000100,
    ST_DP_C       = 21'h000200,
    ST_DP_D       = 21'h000400,
    ST_BT_INIT    = 21'h000800,
    ST_SH_TEST    = 21'h001000,
    ST_SH_RD      = 21'h002000,
    ST_SH_WR      = 21'h004000,
    ST_BP_RD      = 21'h008000,
    ST_BP_WAIT    = 21'h010000,
    ST_RC_INIT    = 21'h020000,
    ST_RC_TEST    = 21'h040000,
    ST_RC_BP_RD   = 21'h080000,
    ST_RC_BP_WAIT = 21'h100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   recomp;
  logic   recomp_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // Next state and per-cycle datapath commands.
  always_comb begin
    state_next  = state;
    recomp_next = recomp;
    cmd         = '0;
    cmd.pix_sel  = PS_READ;
    cmd.prev_sel = PV_CENTER;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_READ) begin
            state_next = ST_READ_OUT;
          end else if (status.load_ok) begin
            cmd.load_pix = 1'b1;
            if (status.load_last) begin
              cmd.p_clear  = 1'b1;
              cmd.s_clear  = 1'b1;
              cmd.cur_init = 1'b1;
              recomp_next  = 1'b0;
              state_next   = ST_EN_A;
            end
          end
        end
      end
      ST_READ_OUT: begin
        cmd.out_capture = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_EN_A: begin
        cmd.pix_sel = PS_HERE;
        state_next  = ST_EN_B;
      end
      ST_EN_B: begin
        cmd.pix_sel    = PS_LEFT;
        cmd.here_latch = 1'b1;
        state_next     = ST_EN_C;
      end
      ST_EN_C: begin
        cmd.pix_sel  = PS_UP;
        cmd.nb_latch = 1'b1;
        state_next   = ST_EN_D;
      end
      ST_EN_D: begin
        cmd.en_write = 1'b1;
        if (recomp) begin
          state_next = ST_RC_BP_RD;
        end else if (status.p_more_len) begin
          cmd.p_inc  = 1'b1;
          state_next = ST_EN_A;
        end else if (status.s_more) begin
          cmd.p_clear = 1'b1;
          cmd.s_inc   = 1'b1;
          state_next  = ST_EN_A;
        end else begin
          state_next = ST_SEAM_CHK;
        end
      end
      ST_SEAM_CHK: begin
        if (status.seam_due) begin
          cmd.p_clear = 1'b1;
          cmd.s_clear = 1'b1;
          state_next  = ST_DP_A;
        end else begin
          cmd.set_carved = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DP_A: begin
        cmd.prev_sel = PV_LEFT;
        state_next   = ST_DP_B;
      end
      ST_DP_B: begin
        cmd.prev_sel      = PV_CENTER;
        cmd.dp_latch_left = 1'b1;
        state_next        = ST_DP_C;
      end
      ST_DP_C: begin
        cmd.prev_sel        = PV_RIGHT;
        cmd.dp_latch_center = 1'b1;
        state_next          = ST_DP_D;
      end
      ST_DP_D: begin
        cmd.dp_write = 1'b1;
        if (status.p_more_cur) begin
          cmd.p_inc  = 1'b1;
          state_next = ST_DP_A;
        end else if (status.s_more) begin
          cmd.p_clear     = 1'b1;
          cmd.s_inc       = 1'b1;
          cmd.bank_toggle = 1'b1;
          state_next      = ST_DP_A;
        end else begin
          state_next = ST_BT_INIT;
        end
      end
      ST_BT_INIT: begin
        cmd.bt_start = 1'b1;
        state_next   = ST_SH_TEST;
      end
      ST_SH_TEST: begin
        state_next = status.shift_more ? ST_SH_RD : ST_BP_RD;
      end
      ST_SH_RD: begin
        cmd.pix_sel = PS_NEXT;
        cmd.en_next = 1'b1;
        state_next  = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd.shift_write = 1'b1;
        cmd.i_inc       = 1'b1;
        state_next      = ST_SH_TEST;
      end
      ST_BP_RD: begin
        state_next = ST_BP_WAIT;
      end
      ST_BP_WAIT: begin
        if (status.s_zero) begin
          state_next = ST_RC_INIT;
        end else begin
          cmd.pos_bp = 1'b1;
          cmd.s_dec  = 1'b1;
          state_next = ST_SH_TEST;
        end
      end
      ST_RC_INIT: begin
        cmd.rc_start = 1'b1;
        state_next   = ST_RC_TEST;
      end
      ST_RC_TEST: begin
        if (status.rc_do) begin
          cmd.p_from_pos = 1'b1;
          recomp_next    = 1'b1;
          state_next     = ST_EN_A;
        end else begin
          state_next = ST_RC_BP_RD;
        end
      end
      ST_RC_BP_RD: begin
        state_next = ST_RC_BP_WAIT;
      end
      ST_RC_BP_WAIT: begin
        if (status.s_zero) begin
          cmd.cur_dec = 1'b1;
          recomp_next = 1'b0;
          state_next  = ST_SEAM_CHK;
        end else begin
          cmd.pos_bp = 1'b1;
          cmd.s_dec  = 1'b1;
          state_next = ST_RC_TEST;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, mode and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      recomp    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      recomp <= recomp_next;
      if (state == ST_READ_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/seam_carving_retarget.sv */
// Top level of the seam carving retargeter.
// Requests arrive on in_valid/in_ready with in_data; opcode OP_LOAD stores one
// pixel in raster order, opcode OP_READ asks for the next carved pixel.
// Load requests give no response and leave the input open, but for the last one.
// A read request gives one response on out_valid/out_ready, formed in state
// ST_READ_OUT; the next request is taken once that response has been delivered.
// past_end marks a read issued before carving is done or after the whole carved
// image has been read. Loading the last pixel starts a blocking carve: an energy
// pass over the image, then per seam a cost search, a backtrack that shifts the
// pixels past the seam along each line, and an energy update along the seam.
// in_ready stays low during the carve. A stalled receiver holds the response
// and no new request is taken. Reset (rst, synchronous) restores the default
// configuration and empties the image; configuration writes on cfg_we do the
// same to the image and must only be issued while the block is idle.
`timescale 1ns / 1ps

module seam_carving_retarget import scr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pixel_out_t            out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  scr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (in_data.opcode),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // Stores and arithmetic.
  scr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

/* hdl/scr_checker.sv */
// Port-level assertion checker for the seam carving block and its bind.
`timescale 1ns / 1ps
`include "seam_carving_retarget_macros.svh"

module scr_checker import scr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input pixel_in_t  in_data,
  input logic       out_valid,
  input logic       out_ready,
  input pixel_out_t out_data
);

  // A response waiting on the receiver holds its value.
  `SCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "response changed while stalled")

  // No new request is taken while a response is pending.
  `SCR_ASSERT_NOW(a_one_pending, in_ready, !out_valid, "request taken with response pending")

  // An accepted read request blocks the input while its response forms.
  `SCR_ASSERT_NEXT(a_read_busy, in_valid && in_ready && in_data.opcode == OP_READ, !in_ready, "input open after read request")

  // A past-end response carries no pixel.
  `SCR_ASSERT_NOW(a_past_zero, out_valid && out_data.past_end, out_data.red_out == '0 && out_data.green_out == '0 && out_data.blue_out == '0 && !out_data.last_pixel, "past-end response has data")

endmodule

bind seam_carving_retarget scr_checker u_scr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
